// ----- sv/text_console_writer_assert.svh -----
// assertion macros for the console writer sequencer
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define TCW_ASSERT_HOLDS(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tcw: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define TCW_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tcw: next-cycle check failed");

`endif

// ----- sv/tcw_pkg.sv -----
`timescale 1ns / 1ps

package tcw_pkg;

   // field widths
   localparam int CHAR_W   = 8;
   localparam int ATTR_W   = 8;
   localparam int ROW_W    = 6;
   localparam int COL_W    = 7;
   localparam int CURSOR_W = 11;

   // default screen geometry
   localparam int DEF_COLUMNS = 80;
   localparam int DEF_ROWS    = 25;

   // configuration registers
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_ATTR = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ERROR_ATTR   = 1'b1;
   localparam logic [ATTR_W-1:0] DEFAULT_ATTR_RESET = 8'd15;
   localparam logic [ATTR_W-1:0] ERROR_ATTR_RESET   = 8'd244;

   // character codes
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE  = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_BLANK_AT = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_SPACE    = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_ERR_MARK = 8'h45;

   typedef enum logic [1:0] {
      KIND_PUT       = 2'd0,
      KIND_BACKSPACE = 2'd1,
      KIND_CLEAR     = 2'd2,
      KIND_READ      = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic [CHAR_W-1:0]    char_code;
      logic [ATTR_W-1:0]    attribute;
      logic                 use_cursor;
      logic [ROW_W-1:0]     row_index;
      logic [COL_W-1:0]     col_index;
   } req_type;

   typedef struct packed {
      logic [CURSOR_W-1:0]  cursor_cell;
      logic                 status;
      logic                 scrolled;
      logic [CHAR_W-1:0]    read_char;
      logic [ATTR_W-1:0]    read_attr;
   } rsp_type;

   // cell store control from the sequencer
   typedef struct packed {
      logic                 we_char;
      logic                 we_attr;
      logic                 re;
      logic [CHAR_W-1:0]    wchar;
      logic [ATTR_W-1:0]    wattr;
   } mem_ctl_type;

endpackage

// ----- sv/text_console_writer.sv -----
`timescale 1ns / 1ps

// Character-cell text console, ROWS x COLUMNS cells of character and attribute.
// req channel: one beat per operation (put, backspace, clear, read), valid/ready.
// rsp channel: exactly one beat per request with cursor cell, status, scroll flag
//   and read data, valid/ready.
// csr port: write enable, index and data; index 0 default attribute, 1 error
//   attribute; write only while no request is in flight.
// Sequence: a request passes ST_CALC, ST_ACCESS and ST_FINISH before its result
//   is registered; a new request is taken only once that result is handed over.
// A put that scrolls then moves the cells up, one cell moved per cycle over the
//   single write port; clear then blanks the cells, one character per cycle.
// Reset: after reset deasserts, a clearing pass over all ROWS*COLUMNS cells zeroes
//   the cell store; req_ready stays low meanwhile, csr writes are taken.
// Stall: the result register holds while rsp_ready is low; the next request
//   is still taken and runs until its own result needs the register.
module text_console_writer #(
   parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
   parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  tcw_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output tcw_pkg::rsp_type                rsp_data,
   input  logic                            csr_write_enable,
   input  logic [tcw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tcw_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import tcw_pkg::*;

   localparam int CELLS  = ROWS * COLUMNS;
   localparam int ADDR_W = $clog2(CELLS);

   logic [ATTR_W-1:0]  default_attr_ff, default_attr_in;
   logic [ATTR_W-1:0]  error_attr_ff, error_attr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic               rsp_free;
   logic               done;
   rsp_type            result;
   mem_ctl_type        mem_ctl;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [ADDR_W-1:0]  mem_raddr;
   logic [CHAR_W-1:0]  rd_char;
   logic [ATTR_W-1:0]  rd_attr;

   // configuration registers
   always_comb begin
      default_attr_in = default_attr_ff;
      error_attr_in   = error_attr_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DEFAULT_ATTR: default_attr_in = csr_write_data[ATTR_W-1:0];
            CSR_ERROR_ATTR:   error_attr_in   = csr_write_data[ATTR_W-1:0];
            default: ;
         endcase
      end
   end

   // result register
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         default_attr_ff <= DEFAULT_ATTR_RESET;
         error_attr_ff   <= ERROR_ATTR_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         default_attr_ff <= default_attr_in;
         error_attr_ff   <= error_attr_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   tcw_seq #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS),
      .CELLS   (CELLS),
      .ADDR_W  (ADDR_W)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .default_attr (default_attr_ff),
      .error_attr   (error_attr_ff),
      .rsp_free     (rsp_free),
      .done         (done),
      .result       (result),
      .mem_ctl      (mem_ctl),
      .mem_waddr    (mem_waddr),
      .mem_raddr    (mem_raddr),
      .rd_char      (rd_char),
      .rd_attr      (rd_attr)
   );

   tcw_store #(
      .CELLS  (CELLS),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock     (clock),
      .mem_ctl   (mem_ctl),
      .mem_waddr (mem_waddr),
      .mem_raddr (mem_raddr),
      .rd_char   (rd_char),
      .rd_attr   (rd_attr)
   );

endmodule

// ----- sv/tcw_store.sv -----
`timescale 1ns / 1ps

module tcw_store #(
   parameter int CELLS  = tcw_pkg::DEF_ROWS * tcw_pkg::DEF_COLUMNS,
   parameter int ADDR_W = $clog2(CELLS)
) (
   input  logic                        clock,
   input  tcw_pkg::mem_ctl_type        mem_ctl,
   input  logic [ADDR_W-1:0]           mem_waddr,
   input  logic [ADDR_W-1:0]           mem_raddr,
   output logic [tcw_pkg::CHAR_W-1:0]  rd_char,
   output logic [tcw_pkg::ATTR_W-1:0]  rd_attr
);
   import tcw_pkg::*;

   logic [CHAR_W-1:0] char_mem [CELLS];
   logic [ATTR_W-1:0] attr_mem [CELLS];
   logic [CHAR_W-1:0] rd_char_ff;
   logic [ATTR_W-1:0] rd_attr_ff;

   // character plane, one write and one registered read
   always_ff @(posedge clock) begin
      if (mem_ctl.we_char) begin
         char_mem[mem_waddr] <= mem_ctl.wchar;
      end
      if (mem_ctl.re) begin
         rd_char_ff <= char_mem[mem_raddr];
      end
   end

   // attribute plane
   always_ff @(posedge clock) begin
      if (mem_ctl.we_attr) begin
         attr_mem[mem_waddr] <= mem_ctl.wattr;
      end
      if (mem_ctl.re) begin
         rd_attr_ff <= attr_mem[mem_raddr];
      end
   end

   assign rd_char = rd_char_ff;
   assign rd_attr = rd_attr_ff;

endmodule

// ----- sv/tcw_seq.sv -----
`timescale 1ns / 1ps

module tcw_seq #(
   parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
   parameter int ROWS    = tcw_pkg::DEF_ROWS,
   parameter int CELLS   = ROWS * COLUMNS,
   parameter int ADDR_W  = $clog2(CELLS)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  tcw_pkg::req_type            req_data,
   input  logic [tcw_pkg::ATTR_W-1:0]  default_attr,
   input  logic [tcw_pkg::ATTR_W-1:0]  error_attr,
   input  logic                        rsp_free,
   output logic                        done,
   output tcw_pkg::rsp_type            result,
   output tcw_pkg::mem_ctl_type        mem_ctl,
   output logic [ADDR_W-1:0]           mem_waddr,
   output logic [ADDR_W-1:0]           mem_raddr,
   input  logic [tcw_pkg::CHAR_W-1:0]  rd_char,
   input  logic [tcw_pkg::ATTR_W-1:0]  rd_attr
);
   import tcw_pkg::*;
   `include "text_console_writer_assert.svh"

   localparam int CNT_W = $clog2(CELLS + 1);
   localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLUMNS);
   localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
   localparam logic [CNT_W-1:0]  CELLS_C   = CNT_W'(CELLS);
   localparam logic [CNT_W-1:0]  LAST_C    = CNT_W'(CELLS - 1);
   localparam logic [CNT_W-1:0]  MOVE_N    = CNT_W'(CELLS - COLUMNS);
   localparam logic [CNT_W-1:0]  COLS_C    = CNT_W'(COLUMNS);
   localparam logic [ROW_W-1:0]  ROWS_R    = ROW_W'(ROWS);
   localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0]  COLS_K    = COL_W'(COLUMNS);
   localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);

   typedef enum logic [6:0] {
      ST_INIT   = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_CALC   = 7'b0000100,
      ST_ACCESS = 7'b0001000,
      ST_SCROLL = 7'b0010000,
      ST_CLEAR  = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   kind_type           op_kind_ff, op_kind_in;
   logic [CHAR_W-1:0]  op_char_ff, op_char_in;
   logic [ATTR_W-1:0]  op_attr_ff, op_attr_in;
   logic               op_bad_ff, op_bad_in;
   logic [ROW_W-1:0]   op_row_ff, op_row_in;
   logic [COL_W-1:0]   op_col_ff, op_col_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [ROW_W-1:0]   cur_row_ff, cur_row_in;
   logic [COL_W-1:0]   cur_col_ff, cur_col_in;
   logic               scroll_ff, scroll_in;

   logic               in_bad;
   logic [ROW_W-1:0]   bs_row, next_row;
   logic [COL_W-1:0]   bs_col, next_col;
   logic [ADDR_W-1:0]  cursor_idx;

   // incoming beat: range check and backspace target
   always_comb begin
      in_bad = !req_data.use_cursor &&
               (req_data.row_index >= ROWS_R || req_data.col_index >= COLS_K);
      if (cur_col_ff != '0) begin
         bs_row = cur_row_ff;
         bs_col = cur_col_ff - COL_W'(1);
      end else if (cur_row_ff != '0) begin
         bs_row = cur_row_ff - ROW_W'(1);
         bs_col = LAST_COL;
      end else begin
         bs_row = '0;
         bs_col = '0;
      end
   end

   // cursor after a put
   always_comb begin
      if (op_char_ff == CHAR_NEWLINE) begin
         next_row = op_row_ff + ROW_W'(1);
         next_col = '0;
      end else if (op_char_ff == CHAR_BLANK_AT) begin
         next_row = op_row_ff;
         next_col = op_col_ff;
      end else if (op_col_ff == LAST_COL) begin
         next_row = op_row_ff + ROW_W'(1);
         next_col = '0;
      end else begin
         next_row = op_row_ff;
         next_col = op_col_ff + COL_W'(1);
      end
   end

   assign cursor_idx = ADDR_W'(cur_row_ff) * COLS_A + ADDR_W'(cur_col_ff);

   // sequencer
   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      op_kind_in = op_kind_ff;
      op_char_in = op_char_ff;
      op_attr_in = op_attr_ff;
      op_bad_in  = op_bad_ff;
      op_row_in  = op_row_ff;
      op_col_in  = op_col_ff;
      addr_in    = addr_ff;
      cur_row_in = cur_row_ff;
      cur_col_in = cur_col_ff;
      scroll_in  = scroll_ff;
      mem_ctl    = '0;
      mem_waddr  = '0;
      mem_raddr  = '0;
      done       = 1'b0;
      req_ready  = 1'b0;
      result     = '0;

      unique case (state_ff)
         // clear both planes after reset
         ST_INIT: begin
            mem_ctl.we_char = 1'b1;
            mem_ctl.we_attr = 1'b1;
            mem_waddr       = idx_ff[ADDR_W-1:0];
            if (idx_ff == LAST_C) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_kind_in = req_data.kind;
               op_char_in = req_data.char_code;
               op_attr_in = (req_data.attribute == '0) ? default_attr : req_data.attribute;
               op_bad_in  = in_bad;
               if (req_data.kind == KIND_BACKSPACE) begin
                  op_row_in = bs_row;
                  op_col_in = bs_col;
               end else if (req_data.use_cursor) begin
                  op_row_in = cur_row_ff;
                  op_col_in = cur_col_ff;
               end else begin
                  op_row_in = req_data.row_index;
                  op_col_in = req_data.col_index;
               end
               state_in = ST_CALC;
            end
         end
         // cell address and new cursor
         ST_CALC: begin
            scroll_in = 1'b0;
            if (op_kind_ff == KIND_PUT && op_bad_ff) begin
               addr_in = LAST_CELL;
            end else begin
               addr_in = ADDR_W'(op_row_ff) * COLS_A + ADDR_W'(op_col_ff);
            end
            unique case (op_kind_ff)
               KIND_PUT: begin
                  if (!op_bad_ff) begin
                     if (next_row == ROWS_R) begin
                        scroll_in  = 1'b1;
                        cur_row_in = LAST_ROW;
                     end else begin
                        cur_row_in = next_row;
                     end
                     cur_col_in = next_col;
                  end
               end
               KIND_BACKSPACE: begin
                  cur_row_in = op_row_ff;
                  cur_col_in = op_col_ff;
               end
               KIND_CLEAR: begin
                  cur_row_in = '0;
                  cur_col_in = '0;
               end
               KIND_READ: begin
               end
            endcase
            state_in = ST_ACCESS;
         end
         // single cell write or read, then on to scroll, clear or finish
         ST_ACCESS: begin
            mem_waddr = addr_ff;
            mem_raddr = addr_ff;
            idx_in    = '0;
            state_in  = ST_FINISH;
            unique case (op_kind_ff)
               KIND_PUT: begin
                  if (op_bad_ff) begin
                     mem_ctl.we_char = 1'b1;
                     mem_ctl.we_attr = 1'b1;
                     mem_ctl.wchar   = CHAR_ERR_MARK;
                     mem_ctl.wattr   = error_attr;
                  end else if (op_char_ff != CHAR_NEWLINE) begin
                     mem_ctl.we_char = 1'b1;
                     mem_ctl.we_attr = 1'b1;
                     mem_ctl.wchar   = (op_char_ff == CHAR_BLANK_AT) ? CHAR_SPACE : op_char_ff;
                     mem_ctl.wattr   = op_attr_ff;
                  end
                  if (scroll_ff) begin
                     state_in = ST_SCROLL;
                  end
               end
               KIND_BACKSPACE: begin
                  mem_ctl.we_char = 1'b1;
                  mem_ctl.we_attr = 1'b1;
                  mem_ctl.wchar   = CHAR_SPACE;
                  mem_ctl.wattr   = default_attr;
               end
               KIND_CLEAR: begin
                  state_in = ST_CLEAR;
               end
               KIND_READ: begin
                  mem_ctl.re = !op_bad_ff;
               end
            endcase
         end
         // move rows up: read one row ahead, write the cell read last cycle; zero the last row
         ST_SCROLL: begin
            mem_ctl.re = (idx_ff < MOVE_N);
            mem_raddr  = ADDR_W'(idx_ff + COLS_C);
            if (idx_ff != '0) begin
               mem_ctl.we_char = 1'b1;
               mem_ctl.we_attr = 1'b1;
               mem_waddr       = ADDR_W'(idx_ff - CNT_W'(1));
               if (idx_ff <= MOVE_N) begin
                  mem_ctl.wchar = rd_char;
                  mem_ctl.wattr = rd_attr;
               end
            end
            if (idx_ff == CELLS_C) begin
               state_in = ST_FINISH;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         // blank every character, attributes untouched
         ST_CLEAR: begin
            mem_ctl.we_char = 1'b1;
            mem_ctl.wchar   = CHAR_SPACE;
            mem_waddr       = idx_ff[ADDR_W-1:0];
            if (idx_ff == LAST_C) begin
               state_in = ST_FINISH;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         // hand the result to the output register
         ST_FINISH: begin
            result.cursor_cell = CURSOR_W'(cursor_idx);
            result.status      = op_bad_ff &&
                                 (op_kind_ff == KIND_PUT || op_kind_ff == KIND_READ);
            result.scrolled    = scroll_ff && op_kind_ff == KIND_PUT;
            if (op_kind_ff == KIND_READ && !op_bad_ff) begin
               result.read_char = rd_char;
               result.read_attr = rd_attr;
            end
            if (rsp_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
            idx_in   = '0;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_INIT;
         idx_ff     <= '0;
         cur_row_ff <= '0;
         cur_col_ff <= '0;
         scroll_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         cur_row_ff <= cur_row_in;
         cur_col_ff <= cur_col_in;
         scroll_ff  <= scroll_in;
      end
   end

   // operation payload
   always_ff @(posedge clock) begin
      op_kind_ff <= op_kind_in;
      op_char_ff <= op_char_in;
      op_attr_ff <= op_attr_in;
      op_bad_ff  <= op_bad_in;
      op_row_ff  <= op_row_in;
      op_col_ff  <= op_col_in;
      addr_ff    <= addr_in;
   end

   `TCW_ASSERT_HOLDS(a_cursor_in_screen, 1'b1, cur_row_ff < ROWS_R && cur_col_ff < COLS_K)
   `TCW_ASSERT_HOLDS(a_write_in_store, mem_ctl.we_char || mem_ctl.we_attr, CNT_W'(mem_waddr) < CELLS_C)
   `TCW_ASSERT_HOLDS(a_scroll_last_row, done && result.scrolled, cur_row_ff == LAST_ROW)
   `TCW_ASSERT_NEXT(a_accept_to_calc, req_valid && req_ready, state_ff == ST_CALC)

endmodule
